// ===== hdl/gfau_pkg.sv =====
// Shared types, operation codes and field arithmetic for the GF(2^8) arithmetic unit.
// No dependencies; every other file of the block but the interfaces refers to it by scoped names.
`default_nettype none

package gfau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_MUL = 2'd1;
  localparam logic [1:0] CMD_INV = 2'd2;
  localparam logic [1:0] CMD_LOG = 2'd3;

  // Low byte of the reduction polynomial x^8 + x^4 + x^3 + x + 1.
  localparam logic [7:0] GF_REDUCE = 8'h1B;
  // Multiplicative group order; also the last exponent index plus one.
  localparam logic [7:0] GF_ORDER = 8'd255;
  localparam logic [7:0] GF_LAST_EXP = 8'd254;
  localparam logic [7:0] GEN_RESET = 8'd3;

  // Table write stream from the builder to the front and back memories.
  typedef struct packed {
    logic       busy;   // tables are being rebuilt
    logic       clear;  // first step of a rebuild: forget all reached values
    logic       we;     // one exponent/element pair to record
    logic [7:0] idx;    // exponent
    logic [7:0] elem;   // generator raised to that exponent
  } tbl_wr_t;

  // One classified request passing from the front to the back.
  typedef struct packed {
    logic       is_inv;  // value is an exponent into the power table
    logic       undef;   // operand zero or never reached
    logic [7:0] value;   // final result, or exponent for inverse
  } q_entry_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] cur;
    acc = 8'd0;
    cur = a;
    for (int bit_idx = 0; bit_idx < 8; bit_idx++) begin
      if (b[bit_idx]) begin
        acc = acc ^ cur;
      end
      if (cur[7]) begin
        cur = {cur[6:0], 1'b0} ^ GF_REDUCE;
      end else begin
        cur = {cur[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gfau_if.sv =====
// Valid/ready channel interfaces for requests, responses and generator writes.
// No dependencies.
`default_nettype none

interface gfau_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] operand_a;
  logic [7:0] operand_b;
  modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
  modport sink (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

interface gfau_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       undefined;
  modport source (output valid, output result, output undefined, input ready);
  modport sink (input valid, input result, input undefined, output ready);
endinterface

interface gfau_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] generator;
  modport source (output valid, output generator, input ready);
  modport sink (input valid, input generator, output ready);
endinterface

`default_nettype wire

// ===== hdl/gfau_builder.sv =====
// Table rebuild sequencer: walks the powers of the generator, one per cycle.
// Depends on gfau_pkg and the configuration channel interface.
`default_nettype none

module gfau_builder (
  input  wire logic       clk,
  input  wire logic       rst,
  gfau_cfg_if.sink        cfg,
  output gfau_pkg::tbl_wr_t wr
);

  logic       busy;
  logic [7:0] gen;
  logic [7:0] idx;
  logic [7:0] cur;

  // A write restarts the rebuild from exponent zero.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      gen  <= gfau_pkg::GEN_RESET;
      idx  <= 8'd0;
      cur  <= 8'd1;
    end else if (cfg.valid) begin
      busy <= 1'b1;
      gen  <= cfg.generator;
      idx  <= 8'd0;
      cur  <= 8'd1;
    end else if (busy) begin
      if (idx == gfau_pkg::GF_LAST_EXP) begin
        busy <= 1'b0;
      end
      idx <= idx + 8'd1;
      cur <= gfau_pkg::gf_mul(cur, gen);
    end
  end

  always_comb begin
    wr.busy  = busy;
    wr.clear = busy && (idx == 8'd0);
    wr.we    = busy;
    wr.idx   = idx;
    wr.elem  = cur;
  end

endmodule

`default_nettype wire

// ===== hdl/gfau_front.sv =====
// Front stage: accepts requests, does add and multiply, looks up logarithms.
// Holds the log table and the reached-value bits. Depends on gfau_pkg and gfau_req_if.
`default_nettype none

module gfau_front (
  input  wire logic                clk,
  input  wire logic                rst,
  gfau_req_if.sink                 req,
  input  wire gfau_pkg::tbl_wr_t   wr,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output gfau_pkg::q_entry_t       push_data
);

  logic [7:0]   log_table [256];
  logic [255:0] log_valid;

  logic       f_valid;
  logic [1:0] f_cmd;
  logic       f_a_zero;
  logic [7:0] f_arith;
  logic [7:0] lg_rd;
  logic       lv_rd;
  logic       accept;
  logic       lookup;

  assign req.ready  = !wr.busy && (!f_valid || push_ready);
  assign accept     = req.valid && req.ready;
  assign push_valid = f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd    <= req.cmd;
      f_a_zero <= (req.operand_a == 8'd0);
      if (req.cmd == gfau_pkg::CMD_ADD) begin
        f_arith <= req.operand_a ^ req.operand_b;
      end else begin
        f_arith <= gfau_pkg::gf_mul(req.operand_a, req.operand_b);
      end
    end
  end

  // Log table: written by the builder, read once per accepted request.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      log_table[wr.elem] <= wr.idx;
    end
    if (accept) begin
      lg_rd <= log_table[req.operand_a];
    end
  end

  // The later exponent overwrites, so the last one reaching a value wins.
  // The first step of a rebuild forgets every value except the one it records.
  always_ff @(posedge clk) begin
    if (wr.clear) begin
      log_valid <= 256'd1 << wr.elem;
    end else if (wr.we) begin
      log_valid[wr.elem] <= 1'b1;
    end
    if (accept) begin
      lv_rd <= log_valid[req.operand_a];
    end
  end

  assign lookup = f_cmd inside {gfau_pkg::CMD_INV, gfau_pkg::CMD_LOG};

  always_comb begin
    push_data.is_inv = (f_cmd == gfau_pkg::CMD_INV);
    push_data.undef  = lookup && (f_a_zero || !lv_rd);
    case (f_cmd)
      gfau_pkg::CMD_ADD, gfau_pkg::CMD_MUL: push_data.value = f_arith;
      gfau_pkg::CMD_LOG:                    push_data.value = lg_rd;
      gfau_pkg::CMD_INV: begin
        // (255 - log) mod 255: log zero maps back to exponent zero.
        if (lg_rd == 8'd0) begin
          push_data.value = 8'd0;
        end else begin
          push_data.value = gfau_pkg::GF_ORDER - lg_rd;
        end
      end
      default: push_data.value = f_arith;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gfau_queue.sv =====
// Two-entry queue between the front and back stages.
// Depends on gfau_pkg for the entry type.
`default_nettype none

module gfau_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire gfau_pkg::q_entry_t push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output gfau_pkg::q_entry_t      pop_data
);

  gfau_pkg::q_entry_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gfau_back.sv =====
// Back stage: reads the power table for inverses and holds the response register.
// Depends on gfau_pkg and gfau_rsp_if.
`default_nettype none

module gfau_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gfau_pkg::tbl_wr_t  wr,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire gfau_pkg::q_entry_t pop_data,
  gfau_rsp_if.source              rsp
);

  logic [7:0] power_table [256];

  logic               o_valid;
  gfau_pkg::q_entry_t o_ent;
  logic [7:0]         pw_rd;
  logic               do_pop;

  assign pop_ready = !o_valid || rsp.ready;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (do_pop) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      o_ent <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      power_table[wr.idx] <= wr.elem;
    end
    if (do_pop) begin
      pw_rd <= power_table[pop_data.value];
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.undefined = o_ent.undef;

  always_comb begin
    if (o_ent.undef) begin
      rsp.result = 8'd0;
    end else if (o_ent.is_inv) begin
      rsp.result = pw_rd;
    end else begin
      rsp.result = o_ent.value;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gf256_arithmetic_unit.sv =====
// Top level of the GF(2^8) arithmetic unit (reduction polynomial 0x11B).
// Depends on gfau_pkg, the channel interfaces, gfau_builder, gfau_front,
// gfau_queue and gfau_back.
//
// Usage:
//   req carries one request per handshake: cmd (0 add, 1 multiply,
//   2 inverse, 3 discrete log) and the bytes operand_a and operand_b.
//   rsp returns exactly one response per request, in order: result and
//   the undefined flag, raised for inverse or log of zero or of a value
//   that no power of the generator reaches (result is then 0).
//   cfg writes the generator that the power and log tables are built from.
//   Reset sets the generator to 3. After reset, and after every generator
//   write, the tables are rebuilt, one exponent per cycle; req.ready
//   stays low during the rebuild. Generator writes are taken at any
//   time and restart the rebuild; they belong in gaps with no request
//   in flight.
//   Throughput is one request per cycle while rsp.ready stays high and
//   no rebuild runs. A request passes the front register (log table
//   read), then the queue, then the response register (power table
//   read), from which its response is offered.
//   When the receiver stalls, the response register holds and the
//   two-entry queue and front register fill before req.ready drops.
`default_nettype none

module gf256_arithmetic_unit (
  input wire logic clk,
  input wire logic rst,
  gfau_req_if.sink   req,
  gfau_rsp_if.source rsp,
  gfau_cfg_if.sink   cfg
);

  gfau_pkg::tbl_wr_t  wr;
  logic               push_valid;
  logic               push_ready;
  gfau_pkg::q_entry_t push_data;
  logic               pop_valid;
  logic               pop_ready;
  gfau_pkg::q_entry_t pop_data;

  // Rebuilds both tables after reset and on every generator write.
  gfau_builder u_builder (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .wr  (wr)
  );

  // Accepts requests, does add and multiply, and reads the log table.
  gfau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .wr         (wr),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouples the front from a stalled back end.
  gfau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Reads the power table for inverses and drives the response channel.
  gfau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
